### rtl/quaternion_to_euler_angles_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to Euler angles block
// Property shorthands clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define QTE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent a fixed number of cycles later.
`define QTE_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

### rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants, arctangent table and rounding helpers shared by the
// quaternion to Euler angles pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN    = 24;
	localparam int IN_W       = 16;
	localparam int PROD_W     = 32;
	localparam int SUM_W      = 34;
	localparam int XY_W       = 36;
	localparam int ANG_W      = 21;
	localparam int RAD_W      = 58;
	localparam int ROOT_W     = 29;
	localparam int REM_W      = 32;
	localparam int SQ_W       = 56;
	localparam int RND_W      = 19;
	localparam int ISQ_STAGES = ROOT_W;
	localparam int PRE_STAGES = 4;

	localparam logic signed [SUM_W-1:0] ONE_Q28     = 34'sd268435456;
	localparam logic [RAD_W-1:0]        ONE_Q56     = {2'b01, 56'd0};
	localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
	localparam logic signed [15:0]      PI_Q13      = 16'sd25736;
	localparam logic signed [15:0]      HALF_PI_Q13 = 16'sd12868;

	// Latency from accepted transaction to result strobe
	function automatic int latency(input int steps);
		return PRE_STAGES + ISQ_STAGES + steps + 2;
	endfunction

	// Values carried alongside the square root pipeline
	typedef struct packed {
		logic signed [SUM_W-1:0] sr;
		logic signed [SUM_W-1:0] cr;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] cy;
		logic signed [SUM_W-1:0] sp;
		logic                    sat_pos;
		logic                    sat_neg;
	} side_t;

	typedef struct packed {
		logic sat_pos;
		logic sat_neg;
	} sat_t;

	// round(atan(2^-i) * 65536)
	function automatic logic [16:0] atan_tab(input logic [4:0] i);
		logic [16:0] r;
		unique case (i)
			5'd0:    r = 17'd51472;
			5'd1:    r = 17'd30386;
			5'd2:    r = 17'd16055;
			5'd3:    r = 17'd8150;
			5'd4:    r = 17'd4091;
			5'd5:    r = 17'd2047;
			5'd6:    r = 17'd1024;
			5'd7:    r = 17'd512;
			5'd8:    r = 17'd256;
			5'd9:    r = 17'd128;
			5'd10:   r = 17'd64;
			5'd11:   r = 17'd32;
			5'd12:   r = 17'd16;
			5'd13:   r = 17'd8;
			5'd14:   r = 17'd4;
			5'd15:   r = 17'd2;
			5'd16:   r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// Round 16 fraction bits to 13, half away from zero
	function automatic logic signed [RND_W-1:0] round_q13(input logic signed [ANG_W-1:0] a);
		logic [ANG_W-1:0] mag;
		logic [ANG_W-1:0] sum;
		logic [RND_W-1:0] r;
		mag = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
		sum = mag + ANG_W'(4);
		r   = RND_W'(sum >> 3);
		return a[ANG_W-1] ? -$signed(r) : $signed(r);
	endfunction

	// Clamp a rounded angle to +/- lim
	function automatic logic signed [15:0] clamp_q13(input logic signed [RND_W-1:0] r,
	                                                 input logic signed [15:0] lim);
		logic signed [RND_W-1:0] l;
		l = RND_W'(lim);
		if (r > l)
			return lim;
		else if (r < -l)
			return -lim;
		else
			return 16'(r);
	endfunction

endpackage

### rtl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [qte_pkg::RAD_W-1:0]  radicand,
	output logic                       out_vld,
	output logic [qte_pkg::ROOT_W-1:0] root
);
	import qte_pkg::*;

	logic [RAD_W-1:0]  rad_s  [ISQ_STAGES];
	logic [REM_W-1:0]  rem_s  [ISQ_STAGES];
	logic [ROOT_W-1:0] root_s [ISQ_STAGES];
	logic              vld_s  [ISQ_STAGES];

	for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic              vld_in;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// bring down two bits and try the next root bit
		assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else
				vld_s[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
			rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
			root_s[k] <= {root_in[ROOT_W-2:0], ge};
		end
	end

	assign out_vld = vld_s[ISQ_STAGES-1];
	assign root    = root_s[ISQ_STAGES-1];

endmodule

### rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) with 16 fraction bits:
// one quadrant stage, then one stage per iteration.
// ----------------------------------------------------------------------------
module qte_cordic #(
	parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic signed [qte_pkg::XY_W-1:0]  vec_y,
	input  logic signed [qte_pkg::XY_W-1:0]  vec_x,
	output logic                             out_vld,
	output logic signed [qte_pkg::ANG_W-1:0] angle
);
	import qte_pkg::*;

	logic signed [XY_W-1:0]  x_s    [STEPS+1];
	logic signed [XY_W-1:0]  y_s    [STEPS+1];
	logic signed [ANG_W-1:0] z_s    [STEPS+1];
	logic                    zero_s [STEPS+1];
	logic                    vld_s  [STEPS+1];

	// Fold the left half plane onto the right one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (vec_x == '0) && (vec_y == '0);
		if (vec_x[XY_W-1]) begin
			x_s[0] <= -vec_x;
			y_s[0] <= -vec_y;
			z_s[0] <= vec_y[XY_W-1] ? -PI_Q16 : PI_Q16;
		end else begin
			x_s[0] <= vec_x;
			y_s[0] <= vec_y;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		logic signed [XY_W-1:0]  xs;
		logic signed [XY_W-1:0]  ys;
		logic signed [ANG_W-1:0] step;

		assign xs   = x_s[i] >>> i;
		assign ys   = y_s[i] >>> i;
		assign step = $signed({{(ANG_W-17){1'b0}}, atan_tab(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else
				vld_s[i+1] <= vld_s[i];
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (!y_s[i][XY_W-1]) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + step;
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - step;
			end
		end
	end

	assign out_vld = vld_s[STEPS];
	assign angle   = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule

### rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q1.14) to negated roll, pitch and negated yaw (Q2.13 rad).
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     start, busy         quat_w, quat_x, quat_y, quat_z
//  result    done (strobe)       roll_angle, pitch_angle, yaw_angle
//
// One transaction per cycle; busy stays low. A result passes through
// four product and setup stages, 29 square root stages,
// CORDIC_STEPS + 1 CORDIC stages and the output register. Reset clears
// the valid bits only. The receiver cannot stall, so the pipeline
// advances every cycle.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [qte_pkg::IN_W-1:0] quat_w,
	input  logic signed [qte_pkg::IN_W-1:0] quat_x,
	input  logic signed [qte_pkg::IN_W-1:0] quat_y,
	input  logic signed [qte_pkg::IN_W-1:0] quat_z,
	output logic                            done,
	output logic signed [15:0]              roll_angle,
	output logic signed [14:0]              pitch_angle,
	output logic signed [15:0]              yaw_angle
);
	import qte_pkg::*;

	localparam int CRD_LAT = CORDIC_STEPS + 1;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PROD_W-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [SUM_W-1:0]  sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;
	logic signed [2*ROOT_W-1:0] sp_sq;
	logic [SQ_W-1:0]          sq_s3;
	side_t                    side_s3, side_s4;
	logic [RAD_W-1:0]         rad_s4;
	side_t                    side_d [ISQ_STAGES];
	sat_t                     sat_d  [CRD_LAT];
	side_t                    side_c;

	logic                     isq_vld;
	logic [ROOT_W-1:0]        isq_root;
	logic                     roll_vld, yaw_vld, pitch_vld;
	logic signed [ANG_W-1:0]  roll_a, yaw_a, pitch_a;

	logic                     done_q;
	logic signed [15:0]       roll_q, yaw_q;
	logic signed [14:0]       pitch_q;
	logic signed [15:0]       pitch_c;

	assign busy = 1'b0;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= pitch_vld && roll_vld && yaw_vld;
		end
	end

	// Stage 1: component products
	always_ff @(posedge clk) begin
		wx_s1 <= quat_w * quat_x;
		yz_s1 <= quat_y * quat_z;
		xx_s1 <= quat_x * quat_x;
		yy_s1 <= quat_y * quat_y;
		wy_s1 <= quat_w * quat_y;
		zx_s1 <= quat_z * quat_x;
		wz_s1 <= quat_w * quat_z;
		xy_s1 <= quat_x * quat_y;
		zz_s1 <= quat_z * quat_z;
	end

	// Stage 2: product sums, 28 fraction bits
	always_ff @(posedge clk) begin
		sr_s2 <= (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
		cr_s2 <= ONE_Q28 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
		sp_s2 <= (SUM_W'(wy_s1) - SUM_W'(zx_s1)) <<< 1;
		sy_s2 <= (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
		cy_s2 <= ONE_Q28 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);
	end

	// Stage 3: pitch saturation and sine squared
	assign sp_sq = $signed(sp_s2[ROOT_W-1:0]) * $signed(sp_s2[ROOT_W-1:0]);

	always_ff @(posedge clk) begin
		sq_s3           <= sp_sq[SQ_W-1:0];
		side_s3.sr      <= sr_s2;
		side_s3.cr      <= cr_s2;
		side_s3.sy      <= sy_s2;
		side_s3.cy      <= cy_s2;
		side_s3.sp      <= sp_s2;
		side_s3.sat_pos <= sp_s2 >= ONE_Q28;
		side_s3.sat_neg <= sp_s2 <= -ONE_Q28;
	end

	// Stage 4: cosine squared as square root radicand
	always_ff @(posedge clk) begin
		rad_s4  <= ONE_Q56 - {2'b00, sq_s3};
		side_s4 <= side_s3;
	end

	qte_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.radicand (rad_s4),
		.out_vld  (isq_vld),
		.root     (isq_root)
	);

	// Hold side values across the square root
	for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) side_d[k] <= side_s4;
		end else begin : g_next
			always_ff @(posedge clk) side_d[k] <= side_d[k-1];
		end
	end

	assign side_c = side_d[ISQ_STAGES-1];

	// Hold saturation flags across the CORDIC
	for (genvar k = 0; k < CRD_LAT; k++) begin : g_sat
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				sat_d[k].sat_pos <= side_c.sat_pos;
				sat_d[k].sat_neg <= side_c.sat_neg;
			end
		end else begin : g_next
			always_ff @(posedge clk) sat_d[k] <= sat_d[k-1];
		end
	end

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (isq_vld),
		.vec_y   (XY_W'(side_c.sr)),
		.vec_x   (XY_W'(side_c.cr)),
		.out_vld (roll_vld),
		.angle   (roll_a)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (isq_vld),
		.vec_y   (XY_W'(side_c.sy)),
		.vec_x   (XY_W'(side_c.cy)),
		.out_vld (yaw_vld),
		.angle   (yaw_a)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (isq_vld),
		.vec_y   (XY_W'(side_c.sp)),
		.vec_x   ($signed({{(XY_W-ROOT_W){1'b0}}, isq_root})),
		.out_vld (pitch_vld),
		.angle   (pitch_a)
	);

	// Select saturated pitch, else the rounded and clamped CORDIC pitch
	always_comb begin
		priority if (sat_d[CRD_LAT-1].sat_pos)
			pitch_c = HALF_PI_Q13;
		else if (sat_d[CRD_LAT-1].sat_neg)
			pitch_c = -HALF_PI_Q13;
		else
			pitch_c = clamp_q13(round_q13(pitch_a), HALF_PI_Q13);
	end

	// Output register: round, clamp, negate roll and yaw
	always_ff @(posedge clk) begin
		roll_q  <= -clamp_q13(round_q13(roll_a), PI_Q13);
		yaw_q   <= -clamp_q13(round_q13(yaw_a), PI_Q13);
		pitch_q <= pitch_c[14:0];
	end

	assign done        = done_q;
	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;

endmodule

### rtl/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on latency, idle handshake and result ranges.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_macros.svh"

module qte_checker #(
	parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] roll_angle,
	input logic signed [14:0] pitch_angle,
	input logic signed [15:0] yaw_angle
);
	import qte_pkg::*;

	localparam int LAT = latency(CORDIC_STEPS);

	`QTE_ASSERT_DLY(a_result_follows, start && !busy, LAT, done, "transaction lost")
	`QTE_ASSERT_IMP(a_result_has_cause, done, $past(start && !busy, LAT), "result invented")
	`QTE_ASSERT_IMP(a_angle_range, done, (roll_angle >= -16'sd25736) && (roll_angle <= 16'sd25736) && (yaw_angle >= -16'sd25736) && (yaw_angle <= 16'sd25736) && (pitch_angle >= -15'sd12868) && (pitch_angle <= 15'sd12868), "angle out of range")
	`QTE_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind quaternion_to_euler_angles qte_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_qte_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles testbench
// Drives quaternions through the command port with random gaps, predicts
// roll, pitch and yaw with a local fixed point CORDIC model and compares
// every result strobe in order against the predicted angles.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STEPS      = qte_pkg::CORDIC_STEPS_DEF;
	localparam int LAT        = qte_pkg::latency(STEPS);
	localparam int N_RANDOM   = 1700;
	localparam int IDLE_LIMIT = 4000;
	localparam longint Q28    = 64'sd1 << 28;
	localparam longint PI16   = 205887;
	localparam longint PI13   = 25736;
	localparam longint HPI13  = 12868;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	// Directed row: quaternion plus optional typed-in angles
	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 known;
		angles_t            ang;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic               busy, done;
	logic signed [15:0] roll_angle, yaw_angle;
	logic signed [14:0] pitch_angle;

	angles_t pending_angles[$];
	int      fail_count = 0;
	int      idle_cycles = 0;

	quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (.*);

	always #4 clk = ~clk;

	// Arctangent table, 16 fraction bits
	function automatic longint atan_entry(input int i);
		longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		return (i < 17) ? t[i] : 0;
	endfunction

	// Arithmetic right shift, floor
	function automatic longint shr_floor(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint vector_angle(input longint yv, input longint xv);
		longint a, nx, ny, xc, yc;
		a = 0;
		xc = xv;
		yc = yv;
		if (xc == 0 && yc == 0)
			return 0;
		if (xc < 0) begin
			a = (yc >= 0) ? PI16 : -PI16;
			xc = -xc;
			yc = -yc;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (yc >= 0) begin
				nx = xc + shr_floor(yc, i);
				ny = yc - shr_floor(xc, i);
				a += atan_entry(i);
			end else begin
				nx = xc - shr_floor(yc, i);
				ny = yc + shr_floor(xc, i);
				a -= atan_entry(i);
			end
			xc = nx;
			yc = ny;
		end
		return a;
	endfunction

	function automatic longint floor_root(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_clamp(input longint a, input longint lim);
		longint r;
		r = (a >= 0) ? ((a + 4) >>> 3) : -(((-a) + 4) >>> 3);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic angles_t euler_of(input logic signed [15:0] qw, qx, qy, qz);
		longint w, x, y, z, sr, cr, sp, sy, cy, c;
		angles_t e;
		w = qw; x = qx; y = qy; z = qz;
		sr = 2 * (w * x + y * z);
		cr = Q28 - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = Q28 - 2 * (y * y + z * z);
		e.roll = 16'(-round_clamp(vector_angle(sr, cr), PI13));
		e.yaw  = 16'(-round_clamp(vector_angle(sy, cy), PI13));
		if (sp >= Q28)
			e.pitch = 15'(HPI13);
		else if (sp <= -Q28)
			e.pitch = 15'(-HPI13);
		else begin
			c = floor_root((64'd1 << 56) - longint'(sp * sp));
			e.pitch = 15'(round_clamp(vector_angle(sp, c), HPI13));
		end
		return e;
	endfunction

	// Send one transaction, then an optional gap
	task automatic send_quat(input logic signed [15:0] w, x, y, z, input bit gap_ok);
		int gap;
		start  <= 1'b1;
		quat_w <= w;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		do
			@(posedge clk);
		while (busy);
		pending_angles.push_back(euler_of(w, x, y, z));
		gap = 0;
		if (gap_ok && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// Compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		angles_t e;
		if (done) begin
			if (pending_angles.size() == 0) begin
				$error("result without pending transaction");
				fail_count++;
			end else begin
				e = pending_angles.pop_front();
				if (roll_angle !== e.roll) begin
					$error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
					fail_count++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
					fail_count++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction or result
	always @(posedge clk) begin
		if (done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("quaternion_to_euler_angles: mismatch");
			$finish;
		end
	end

	initial begin
		row_t    rows[$];
		row_t    r;
		angles_t got;
		logic signed [15:0] qw, qx, qy, qz;
		int      kind;

		// Identity, saturated pitch, zero vector, negative x axis, extremes
		rows.push_back('{16384, 0, 0, 0, 1, '{0, 0, 0}});
		rows.push_back('{16384, 0, 8192, 0, 1, '{0, 12868, 0}});
		rows.push_back('{16384, 0, -8192, 0, 1, '{0, -12868, 0}});
		rows.push_back('{0, 0, 16384, 0, 0, '{0, 0, 0}});
		rows.push_back('{0, 16384, 0, 0, 0, '{0, 0, 0}});
		rows.push_back('{0, 0, 0, 16384, 0, '{0, 0, 0}});
		rows.push_back('{0, 0, 0, 0, 0, '{0, 0, 0}});
		rows.push_back('{-16384, -16384, -16384, -16384, 0, '{0, 0, 0}});
		rows.push_back('{16384, 16384, 16384, 16384, 0, '{0, 0, 0}});
		rows.push_back('{-32768, -32768, -32768, -32768, 0, '{0, 0, 0}});
		rows.push_back('{32767, 32767, 32767, 32767, 0, '{0, 0, 0}});
		rows.push_back('{32767, -32768, 32767, -32768, 0, '{0, 0, 0}});
		rows.push_back('{-32768, 32767, -32768, 32767, 0, '{0, 0, 0}});
		rows.push_back('{11585, 11585, 0, 0, 0, '{0, 0, 0}});
		rows.push_back('{11585, 0, 0, -11585, 0, '{0, 0, 0}});
		rows.push_back('{8192, 8192, 8192, 8192, 0, '{0, 0, 0}});
		rows.push_back('{1, -1, 1, -1, 0, '{0, 0, 0}});
		rows.push_back('{-21846, 0, 21846, 0, 0, '{0, 0, 0}});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			send_quat(r.w, r.x, r.y, r.z, 1'b0);
			if (r.known) begin
				got = pending_angles[$];
				if (got != r.ang) begin
					$error("directed row %0d prediction roll %0d pitch %0d yaw %0d",
						i, got.roll, got.pitch, got.yaw);
					fail_count++;
				end
			end
		end

		// Hold off until the pipeline has drained
		start <= 1'b0;
		wait (pending_angles.size() == 0);
		@(posedge clk);

		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				// Random components, each shifted right by up to two bits
				qw = rand_comp(); qx = rand_comp(); qy = rand_comp(); qz = rand_comp();
				qw = 16'($signed(qw) >>> $urandom_range(0, 2));
				qx = 16'($signed(qx) >>> $urandom_range(0, 2));
				qy = 16'($signed(qy) >>> $urandom_range(0, 2));
				qz = 16'($signed(qz) >>> $urandom_range(0, 2));
			end else if (kind < 9) begin
				// Near gimbal lock: wy - zx close to plus or minus one half
				qw = 16'($signed($urandom_range(11000, 12200)));
				qy = ($urandom_range(0, 1)) ? qw : -qw;
				qx = 16'($signed($urandom_range(0, 400)) - 200);
				qz = 16'($signed($urandom_range(0, 400)) - 200);
			end else begin
				qw = 16'($urandom); qx = 16'($urandom);
				qy = 16'($urandom); qz = 16'($urandom);
			end
			send_quat(qw, qx, qy, qz, n % 400 < 300);
		end
		start <= 1'b0;

		wait (pending_angles.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (fail_count == 0)
			$display("quaternion_to_euler_angles: match");
		else
			$display("quaternion_to_euler_angles: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles.sv
rtl/qte_checker.sv
bench/testbench.sv
